[hw/rtl/bte_pkg.sv]
package bte_pkg;

    localparam logic [1:0] MODE_RAW = 2'd0;
    localparam logic [1:0] MODE_BIN = 2'd1;
    localparam logic [1:0] MODE_B64 = 2'd2;

    localparam logic REG_OUTPUT_MODE     = 1'b0;
    localparam logic REG_SCRAMBLE_ENABLE = 1'b1;

    localparam logic [1:0] OUTPUT_MODE_RESET     = MODE_B64;
    localparam logic       SCRAMBLE_ENABLE_RESET = 1'b1;

    localparam logic [7:0] NIBBLE_FLIP = 8'hF0;
    localparam logic [7:0] PAD_CHAR    = 8'd61;
    localparam logic [7:0] ZERO_CHAR   = 8'd48;

    typedef enum logic [1:0] {
        OP_RAW = 2'd0,
        OP_BIN = 2'd1,
        OP_B64 = 2'd2
    } bte_op_t;

    // One encode job: bytes packed b0 in [23:16], b1 in [15:8], b2 in [7:0].
    typedef struct packed {
        bte_op_t     op;
        logic [23:0] data;
        logic [1:0]  nbytes;
        logic        last;
    } bte_job_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'd97 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'd48 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'd43;
        end else begin
            c = 8'd47;
        end
        return c;
    endfunction

endpackage

[hw/rtl/bte_fifo.sv]
module bte_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bte_pkg::bte_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output bte_pkg::bte_job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bte_pkg::bte_job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/bte_front.sv]
module bte_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_last_byte,
    input  logic              q_full,
    output logic              q_push,
    output bte_pkg::bte_job_t q_job
);

    logic [1:0]  output_mode_reg, output_mode_next;
    logic        scramble_enable_reg, scramble_enable_next;
    logic [15:0] held_reg, held_next;
    logic [1:0]  phase_reg, phase_next;

    logic       cfg_wr;
    logic       reg_sel;
    logic       accept;
    logic [7:0] b;

    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = scramble_enable_reg ? (s_data_byte ^ bte_pkg::NIBBLE_FLIP) : s_data_byte;

    always_comb begin
        case (reg_sel)
            bte_pkg::REG_OUTPUT_MODE:     prdata = {30'd0, output_mode_reg};
            bte_pkg::REG_SCRAMBLE_ENABLE: prdata = {31'd0, scramble_enable_reg};
            default:                      prdata = '0;
        endcase
    end

    always_comb begin
        output_mode_next     = output_mode_reg;
        scramble_enable_next = scramble_enable_reg;
        if (cfg_wr) begin
            case (reg_sel)
                bte_pkg::REG_OUTPUT_MODE:     output_mode_next     = pwdata[1:0];
                bte_pkg::REG_SCRAMBLE_ENABLE: scramble_enable_next = pwdata[0];
                default: ;
            endcase
        end
    end

    // Classify the request; base64 groups are assembled here.
    always_comb begin
        held_next     = held_reg;
        phase_next    = phase_reg;
        q_push        = 1'b0;
        q_job.op      = bte_pkg::OP_RAW;
        q_job.data    = {b, 16'd0};
        q_job.nbytes  = 2'd1;
        q_job.last    = s_last_byte;
        if (accept) begin
            case (output_mode_reg)
                bte_pkg::MODE_RAW: begin
                    q_push   = 1'b1;
                    q_job.op = bte_pkg::OP_RAW;
                end
                bte_pkg::MODE_BIN: begin
                    q_push   = 1'b1;
                    q_job.op = bte_pkg::OP_BIN;
                end
                bte_pkg::MODE_B64: begin
                    q_job.op = bte_pkg::OP_B64;
                    if (phase_reg == 2'd1) begin
                        if (!s_last_byte) begin
                            held_next  = {held_reg[7:0], b};
                            phase_next = 2'd2;
                        end else begin
                            q_push       = 1'b1;
                            q_job.data   = {held_reg[7:0], b, 8'd0};
                            q_job.nbytes = 2'd2;
                            held_next    = '0;
                            phase_next   = 2'd0;
                        end
                    end else if (phase_reg == 2'd2) begin
                        q_push       = 1'b1;
                        q_job.data   = {held_reg, b};
                        q_job.nbytes = 2'd3;
                        held_next    = '0;
                        phase_next   = 2'd0;
                    end else begin
                        // phase 3 cannot occur; handled as an empty group
                        if (!s_last_byte) begin
                            held_next  = {8'd0, b};
                            phase_next = 2'd1;
                        end else begin
                            q_push       = 1'b1;
                            q_job.nbytes = 2'd1;
                            held_next    = '0;
                            phase_next   = 2'd0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_mode_reg     <= bte_pkg::OUTPUT_MODE_RESET;
            scramble_enable_reg <= bte_pkg::SCRAMBLE_ENABLE_RESET;
            held_reg            <= '0;
            phase_reg           <= '0;
        end else begin
            output_mode_reg     <= output_mode_next;
            scramble_enable_reg <= scramble_enable_next;
            held_reg            <= held_next;
            phase_reg           <= phase_next;
        end
    end

endmodule

[hw/rtl/bte_back.sv]
module bte_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  bte_pkg::bte_job_t q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_char,
    output logic              m_last_char
);

    bte_pkg::bte_job_t job_reg, job_next;
    logic       busy_reg, busy_next;
    logic [2:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_char_reg, m_char_next;
    logic       m_last_reg, m_last_next;

    logic       out_load;
    logic       at_end;
    logic [2:0] last_idx;
    logic [7:0] cur_char;
    logic [7:0] shifted;
    logic [5:0] sextet;
    logic       is_pad;

    always_comb begin
        case (job_reg.op)
            bte_pkg::OP_RAW: last_idx = 3'd0;
            bte_pkg::OP_BIN: last_idx = 3'd7;
            bte_pkg::OP_B64: last_idx = 3'd3;
            default:         last_idx = 3'd0;
        endcase
    end

    always_comb begin
        case (idx_reg[1:0])
            2'd0:    sextet = job_reg.data[23:18];
            2'd1:    sextet = job_reg.data[17:12];
            2'd2:    sextet = job_reg.data[11:6];
            default: sextet = job_reg.data[5:0];
        endcase
        // one byte pads the last two characters, two bytes pad the last one
        is_pad  = ({1'b0, idx_reg[1:0]} > {1'b0, job_reg.nbytes});
        shifted = job_reg.data[23:16] << idx_reg;
        case (job_reg.op)
            bte_pkg::OP_RAW: cur_char = job_reg.data[23:16];
            bte_pkg::OP_BIN: cur_char = bte_pkg::ZERO_CHAR + {7'd0, shifted[7]};
            bte_pkg::OP_B64: cur_char = is_pad ? bte_pkg::PAD_CHAR : bte_pkg::b64_char(sextet);
            default:         cur_char = job_reg.data[23:16];
        endcase
    end

    assign out_load = busy_reg && (!m_valid_reg || m_ready);
    assign at_end   = (idx_reg == last_idx);
    assign q_pop    = q_not_empty && (!busy_reg || (out_load && at_end));

    always_comb begin
        job_next     = job_reg;
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            m_char_next  = cur_char;
            m_last_next  = job_reg.last && at_end;
            idx_next     = idx_reg + 1'b1;
            if (at_end) begin
                busy_next = 1'b0;
            end
        end
        if (q_pop) begin
            job_next  = q_head;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_char  = m_char_reg;
    assign m_last_char = m_last_reg;

endmodule

[hw/rtl/byte_stream_text_encoder_unit.sv]
// Path: byte accepted, job queued, job loaded into the serializer, each character registered.
// Throughput: one character per cycle from the output stage while m_ready holds and jobs wait;
// one character per byte in raw mode, eight in binary mode, and four per three-byte base64 group.
// A small job queue between classifier and serializer absorbs output stalls.
// Reset (aresetn, synchronous): mode base64, scrambling on, group state, queue and output cleared.
module byte_stream_text_encoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_last_char
);

    bte_pkg::bte_job_t push_job;
    bte_pkg::bte_job_t head_job;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_not_empty;

    assign pready = 1'b1;

    bte_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    bte_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    bte_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (head_job),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int TOTAL_REQS     = 380;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 8;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        logic [7:0] data;
        logic       last;
    } byte_req_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_char;
    logic        m_last_char;

    byte_req_t  byte_q[$];
    text_char_t text_q[$];

    // encoder state as predicted
    logic [1:0]  enc_mode = bte_pkg::OUTPUT_MODE_RESET;
    logic        enc_scramble = bte_pkg::SCRAMBLE_ENABLE_RESET;
    logic [15:0] grp_held = '0;
    logic [1:0]  grp_count = '0;

    int  fail_cnt = 0;
    int  cycle_cnt = 0;
    int  req_cnt = 0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    bit  tx_idle_on = 1'b0;
    bit  rx_idle_on = 1'b0;
    bit  hold_arm = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_cnt = 0;
    logic rx_hold = 1'b0;

    byte_stream_text_encoder_unit u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data_byte(s_data_byte),
        .s_last_byte(s_last_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last_char(m_last_char)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] b64_sym(logic [5:0] v);
        return B64_ALPHABET[8*(63 - int'(v)) +: 8];
    endfunction

    function void push_char(logic [7:0] c, logic l);
        text_q.push_back('{c, l});
    endfunction

    function void clear_group();
        grp_held = '0;
        grp_count = '0;
    endfunction

    function void encode_byte(logic [7:0] din, logic last);
        logic [7:0] b;
        logic [7:0] b0;
        logic [7:0] b1;
        b = enc_scramble ? (din ^ bte_pkg::NIBBLE_FLIP) : din;
        case (enc_mode)
            bte_pkg::MODE_RAW: begin
                push_char(b, last);
            end
            bte_pkg::MODE_BIN: begin
                for (int i = 7; i >= 0; i--)
                    push_char(bte_pkg::ZERO_CHAR + {7'd0, b[i]}, last && i == 0);
            end
            bte_pkg::MODE_B64: begin
                if (grp_count == 2'd1) begin
                    if (!last) begin
                        grp_held = {grp_held[7:0], b};
                        grp_count = 2'd2;
                    end else begin
                        b0 = grp_held[7:0];
                        push_char(b64_sym(b0[7:2]), 1'b0);
                        push_char(b64_sym({b0[1:0], b[7:4]}), 1'b0);
                        push_char(b64_sym({b[3:0], 2'b00}), 1'b0);
                        push_char(bte_pkg::PAD_CHAR, 1'b1);
                        clear_group();
                    end
                end else if (grp_count == 2'd2) begin
                    b0 = grp_held[15:8];
                    b1 = grp_held[7:0];
                    push_char(b64_sym(b0[7:2]), 1'b0);
                    push_char(b64_sym({b0[1:0], b1[7:4]}), 1'b0);
                    push_char(b64_sym({b1[3:0], b[7:6]}), 1'b0);
                    push_char(b64_sym(b[5:0]), last);
                    clear_group();
                end else begin
                    // count 3 never happens; handled like an empty group
                    if (!last) begin
                        grp_held = {8'd0, b};
                        grp_count = 2'd1;
                    end else begin
                        push_char(b64_sym(b[7:2]), 1'b0);
                        push_char(b64_sym({b[1:0], 4'd0}), 1'b0);
                        push_char(bte_pkg::PAD_CHAR, 1'b0);
                        push_char(bte_pkg::PAD_CHAR, 1'b1);
                        clear_group();
                    end
                end
            end
            default: begin
                // unused mode: byte dropped, group left alone
            end
        endcase
    endfunction

    function automatic int draw_gap(bit on);
        if (!on || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic cfg_write(logic reg_idx, logic [1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {30'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == bte_pkg::REG_OUTPUT_MODE)
            enc_mode = value;
        else
            enc_scramble = value[0];
    endtask

    task automatic set_config(logic [1:0] mode, logic scramble);
        cfg_write(bte_pkg::REG_OUTPUT_MODE, mode);
        cfg_write(bte_pkg::REG_SCRAMBLE_ENABLE, {1'b0, scramble});
    endtask

    task automatic add_req(logic [7:0] d, logic l);
        byte_q.push_back('{d, l});
        req_cnt++;
    endtask

    task automatic add_random_reqs(int n);
        int left;
        logic l;
        left = 0;
        for (int i = 0; i < n; i++) begin
            if (left == 0)
                left = $urandom_range(1, 9);
            left--;
            l = (left == 0);
            // occasional broken stream: stray or missing last mark
            if ($urandom_range(0, 15) == 0)
                l = ~l;
            add_req(pick_byte(), l);
        end
    endtask

    // sample at negedge so the driver's pop and valid are settled
    task automatic drain();
        do
            @(negedge aclk);
        while (byte_q.size() != 0 || s_valid || text_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : drive_proc
        byte_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_valid && s_ready)
                encode_byte(s_data_byte, s_last_byte);
            if (!s_valid || s_ready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    nxt = byte_q.pop_front();
                    s_valid <= 1'b1;
                    s_data_byte <= nxt.data;
                    s_last_byte <= nxt.last;
                    tx_wait = draw_gap(tx_idle_on);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_proc
        text_char_t want;
        logic       rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (text_q.size() == 0) begin
                    $error("unexpected char: out_char %h last_char %b",
                           m_out_char, m_last_char);
                    fail_cnt++;
                end else begin
                    want = text_q.pop_front();
                    if (m_out_char !== want.ch) begin
                        $error("out_char: expected %h, actual %h", want.ch, m_out_char);
                        fail_cnt++;
                    end
                    if (m_last_char !== want.last) begin
                        $error("last_char: expected %b, actual %b", want.last, m_last_char);
                        fail_cnt++;
                    end
                end
                rx_wait = draw_gap(rx_idle_on);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_ready <= rdy && !rx_hold;
        end
    end

    // one long receiver stall so the job queue fills and s_ready drops
    always @(posedge aclk) begin
        if (hold_arm && !hold_done) begin
            if (hold_cnt < RX_HOLD_CYCLES) begin
                hold_cnt++;
                rx_hold <= 1'b1;
            end else begin
                rx_hold <= 1'b0;
                hold_done = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        int n;
        int pick;
        logic [1:0] mode;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: base64 with scrambling
        add_req(8'h00, 1'b0);
        add_req(8'hFF, 1'b0);
        add_req(8'hA5, 1'b1);
        add_req(8'hFF, 1'b1);
        add_req(8'h00, 1'b0);
        add_req(8'h7F, 1'b1);
        add_req(8'h3C, 1'b0);
        add_req(8'hC3, 1'b0);
        add_req(8'h80, 1'b0);
        add_req(8'h01, 1'b1);
        drain();

        set_config(bte_pkg::MODE_RAW, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(8'hFF, 1'b1);
        drain();

        set_config(bte_pkg::MODE_BIN, 1'b1);
        add_req(8'h01, 1'b0);
        add_req(8'hFE, 1'b1);
        drain();

        // base64 group interrupted by other modes, resumed later
        set_config(bte_pkg::MODE_B64, 1'b0);
        add_req(8'h12, 1'b0);
        drain();
        set_config(bte_pkg::MODE_BIN, 1'b0);
        add_req(8'h34, 1'b1);
        drain();
        set_config(bte_pkg::MODE_B64, 1'b0);
        add_req(8'h56, 1'b0);
        drain();
        set_config(bte_pkg::MODE_RAW, 1'b1);
        add_req(8'h9A, 1'b0);
        drain();
        set_config(bte_pkg::MODE_B64, 1'b0);
        add_req(8'h78, 1'b1);
        drain();

        // unused mode drops everything, last mark too
        set_config(MODE_UNUSED, 1'b1);
        add_req(8'h9A, 1'b1);
        add_req(8'hBC, 1'b0);
        drain();
        set_config(bte_pkg::MODE_B64, 1'b1);
        add_req(8'h55, 1'b1);
        drain();

        // sender keeps offering while the receiver holds off
        set_config(bte_pkg::MODE_BIN, 1'($urandom_range(0, 1)));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_arm = 1'b1;
        add_random_reqs(24);
        drain();

        while (req_cnt < TOTAL_REQS) begin
            pick = $urandom_range(0, 11);
            if (pick < 3)
                mode = bte_pkg::MODE_RAW;
            else if (pick < 5)
                mode = bte_pkg::MODE_BIN;
            else if (pick < 11)
                mode = bte_pkg::MODE_B64;
            else
                mode = MODE_UNUSED;
            set_config(mode, 1'($urandom_range(0, 1)));
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on = ($urandom_range(0, 2) != 0);
            n = $urandom_range(10, 40);
            add_random_reqs(n);
            drain();
        end

        if (fail_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[byte_stream_text_encoder_unit.f]
hw/rtl/bte_pkg.sv
hw/rtl/bte_fifo.sv
hw/rtl/bte_front.sv
hw/rtl/bte_back.sv
hw/rtl/byte_stream_text_encoder_unit.sv
tb/tb.sv
